// ===== rtl/core/pbw_pkg.sv =====
// shared widths, register indexes and stage control type for the beam weighting block
`default_nettype none
package pbw_pkg;

  localparam int BEAM_W   = 18;
  localparam int PIX_W    = 24;
  localparam int WEIGHT_W = 24;
  localparam int OUT_W    = 48;
  localparam int CFG_IDX_W = 8;

  localparam int NUM_BEAM = 8;
  localparam int NUM_PIX  = 4;
  localparam int NUM_OUT  = 4;

  localparam int P1_W  = BEAM_W + PIX_W;
  localparam int T_W   = P1_W + 2;
  localparam int P2_W  = T_W + BEAM_W;
  localparam int R_W   = P2_W + 1;
  localparam int MAG_W = R_W - 1;
  localparam int LO_W  = 32;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int PLO_W = LO_W + WEIGHT_W;
  localparam int PHI_W = HI_W + WEIGHT_W;
  localparam int SUM_W = PLO_W;
  localparam int RND_SHIFT = 8;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RND_SHIFT - 1);
  localparam logic [OUT_W-1:0] OUT_MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MAX_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_XX      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_XY_REAL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_XY_IMAG = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_YY      = CFG_IDX_W'(3);

  typedef struct packed {
    logic en_mag;
    logic en_mul;
    logic en_out;
  } pbw_adv_t;

endpackage
`default_nettype wire

// ===== rtl/core/pbw_in_if.sv =====
// input channel: beam jones matrix and polarization pixels
`default_nettype none
interface pbw_in_if;
  logic valid;
  logic ready;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_xx_re;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_xx_im;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_xy_re;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_xy_im;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_yx_re;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_yx_im;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_yy_re;
  logic signed [pbw_pkg::BEAM_W-1:0] beam_yy_im;
  logic signed [pbw_pkg::PIX_W-1:0] pix_xx;
  logic signed [pbw_pkg::PIX_W-1:0] pix_xy_real;
  logic signed [pbw_pkg::PIX_W-1:0] pix_xy_imag;
  logic signed [pbw_pkg::PIX_W-1:0] pix_yy;

  modport source (
    output valid, beam_xx_re, beam_xx_im, beam_xy_re, beam_xy_im,
    output beam_yx_re, beam_yx_im, beam_yy_re, beam_yy_im,
    output pix_xx, pix_xy_real, pix_xy_imag, pix_yy,
    input  ready
  );
  modport sink (
    input  valid, beam_xx_re, beam_xx_im, beam_xy_re, beam_xy_im,
    input  beam_yx_re, beam_yx_im, beam_yy_re, beam_yy_im,
    input  pix_xx, pix_xy_real, pix_xy_imag, pix_yy,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/pbw_out_if.sv =====
// result channel: weighted polarization values
`default_nettype none
interface pbw_out_if;
  logic valid;
  logic ready;
  logic signed [pbw_pkg::OUT_W-1:0] out_xx;
  logic signed [pbw_pkg::OUT_W-1:0] out_xy_real;
  logic signed [pbw_pkg::OUT_W-1:0] out_xy_imag;
  logic signed [pbw_pkg::OUT_W-1:0] out_yy;

  modport source (
    output valid, out_xx, out_xy_real, out_xy_imag, out_yy,
    input  ready
  );
  modport sink (
    input  valid, out_xx, out_xy_real, out_xy_imag, out_yy,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/pbw_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface pbw_cfg_if;
  logic valid;
  logic ready;
  logic [pbw_pkg::CFG_IDX_W-1:0] index;
  logic [pbw_pkg::WEIGHT_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/pbw_weigh.sv =====
// weighting slice: magnitude, split weight multiply, round, saturate, restore sign
`default_nettype none
module pbw_weigh (
  input  wire logic                                 clk,
  input  wire pbw_pkg::pbw_adv_t                    adv,
  input  wire logic signed [pbw_pkg::R_W-1:0]       value,
  input  wire logic        [pbw_pkg::WEIGHT_W-1:0]  weight,
  output logic signed      [pbw_pkg::OUT_W-1:0]     result
);

  logic                          neg_mag_r, neg_mag_nxt;
  logic [pbw_pkg::MAG_W-1:0]     mag_r, mag_nxt;
  logic                          neg_mul_r;
  logic [pbw_pkg::PLO_W-1:0]     plo_r, plo_nxt;
  logic [pbw_pkg::PHI_W-1:0]     phi_r, phi_nxt;
  logic [pbw_pkg::OUT_W-1:0]     res_r, res_nxt;
  logic [pbw_pkg::SUM_W-1:0]     sum;
  logic [pbw_pkg::OUT_W-1:0]     quo;
  logic [pbw_pkg::OUT_W-1:0]     quo_sat;

  always_comb begin
    neg_mag_nxt = value[pbw_pkg::R_W-1];
    if (neg_mag_nxt) begin
      mag_nxt = pbw_pkg::MAG_W'(-value);
    end else begin
      mag_nxt = pbw_pkg::MAG_W'(value);
    end
  end

  always_comb begin
    plo_nxt = pbw_pkg::PLO_W'(mag_r[pbw_pkg::LO_W-1:0]) * pbw_pkg::PLO_W'(weight);
    phi_nxt = pbw_pkg::PHI_W'(mag_r[pbw_pkg::MAG_W-1:pbw_pkg::LO_W]) * pbw_pkg::PHI_W'(weight);
  end

  always_comb begin
    sum = pbw_pkg::SUM_W'(phi_r) + pbw_pkg::SUM_W'(plo_r[pbw_pkg::PLO_W-1:pbw_pkg::LO_W])
        + pbw_pkg::ROUND_HALF;
    quo = pbw_pkg::OUT_W'(sum >> pbw_pkg::RND_SHIFT);
    if (neg_mul_r) begin
      quo_sat = (quo > pbw_pkg::OUT_MAX_NEG) ? pbw_pkg::OUT_MAX_NEG : quo;
      res_nxt = -quo_sat;
    end else begin
      quo_sat = (quo > pbw_pkg::OUT_MAX_POS) ? pbw_pkg::OUT_MAX_POS : quo;
      res_nxt = quo_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en_mag) begin
      neg_mag_r <= neg_mag_nxt;
      mag_r     <= mag_nxt;
    end
    if (adv.en_mul) begin
      neg_mul_r <= neg_mag_r;
      plo_r     <= plo_nxt;
      phi_r     <= phi_nxt;
    end
    if (adv.en_out) begin
      res_r <= res_nxt;
    end
  end

  assign result = $signed(res_r);

endmodule
`default_nettype wire

// ===== rtl/core/polarimetric_beam_weighting.sv =====
// Per-pixel polarimetric beam weighting: R = B * I * B^H on a 2x2 complex Jones matrix
// with the four image values forming the Hermitian coherency matrix I, then each of
// Re R00, Re R01, Im R01 and Re R11 multiplied by its Q8.16 weight, rounded half away
// from zero to Q31.16 and saturated. One transaction is accepted every clock cycle
// while the pipeline is not stalled by the result side. The eight stages are the input
// register, two multiply/sum pairs for B*I and T*B^H, magnitude, split weight
// multiply, round and saturate. Every stage holds its own valid bit and fills
// bubbles when the result side stalls. Weights reset to 1.0 and are written through
// the configuration channel, which is always ready; indexes past the last weight are
// ignored.
`default_nettype none
module polarimetric_beam_weighting (
  input wire logic clk,
  input wire logic rst_n,
  pbw_in_if.sink   in_chan,
  pbw_out_if.source out_chan,
  pbw_cfg_if.sink  cfg_chan
);

  localparam int NST = 8;

  logic [NST:1]   v_r, v_nxt;
  logic [NST+1:1] rdy;

  logic [pbw_pkg::WEIGHT_W-1:0] weight_r [pbw_pkg::NUM_OUT];

  logic signed [pbw_pkg::BEAM_W-1:0] b1_r [pbw_pkg::NUM_BEAM];
  logic signed [pbw_pkg::PIX_W-1:0]  pix1_r [pbw_pkg::NUM_PIX];
  logic signed [pbw_pkg::BEAM_W-1:0] b2_r [pbw_pkg::NUM_BEAM];
  logic signed [pbw_pkg::P1_W-1:0]   p2_r [24];
  logic signed [pbw_pkg::P1_W-1:0]   p2_nxt [24];
  logic signed [pbw_pkg::BEAM_W-1:0] b3_r [pbw_pkg::NUM_BEAM];
  logic signed [pbw_pkg::T_W-1:0]    t3_r [8];
  logic signed [pbw_pkg::T_W-1:0]    t3_nxt [8];
  logic signed [pbw_pkg::P2_W-1:0]   p4_r [16];
  logic signed [pbw_pkg::P2_W-1:0]   p4_nxt [16];
  logic signed [pbw_pkg::R_W-1:0]    r5_r [pbw_pkg::NUM_OUT];
  logic signed [pbw_pkg::R_W-1:0]    r5_nxt [pbw_pkg::NUM_OUT];
  logic signed [pbw_pkg::OUT_W-1:0]  res [pbw_pkg::NUM_OUT];

  pbw_pkg::pbw_adv_t adv;

  // stage handshake with bubble collapse
  always_comb begin
    rdy[NST+1] = out_chan.ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = ~v_r[k] | rdy[k+1];
    end
    v_nxt[1] = rdy[1] ? in_chan.valid : v_r[1];
    for (int k = 2; k <= NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_chan.ready  = rdy[1];
  assign out_chan.valid = v_r[NST];
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // weight registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pbw_pkg::NUM_OUT; i++) begin
        weight_r[i] <= pbw_pkg::WEIGHT_RESET;
      end
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pbw_pkg::REG_WEIGHT_XX:      weight_r[0] <= cfg_chan.data;
        pbw_pkg::REG_WEIGHT_XY_REAL: weight_r[1] <= cfg_chan.data;
        pbw_pkg::REG_WEIGHT_XY_IMAG: weight_r[2] <= cfg_chan.data;
        pbw_pkg::REG_WEIGHT_YY:      weight_r[3] <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b1_r[0]   <= in_chan.beam_xx_re;
      b1_r[1]   <= in_chan.beam_xx_im;
      b1_r[2]   <= in_chan.beam_xy_re;
      b1_r[3]   <= in_chan.beam_xy_im;
      b1_r[4]   <= in_chan.beam_yx_re;
      b1_r[5]   <= in_chan.beam_yx_im;
      b1_r[6]   <= in_chan.beam_yy_re;
      b1_r[7]   <= in_chan.beam_yy_im;
      pix1_r[0] <= in_chan.pix_xx;
      pix1_r[1] <= in_chan.pix_xy_real;
      pix1_r[2] <= in_chan.pix_xy_imag;
      pix1_r[3] <= in_chan.pix_yy;
    end
  end

  // stage 2: products of B * I, per beam row k
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      // left column of the row: re then im
      p2_nxt[12*k+0]  = pbw_pkg::P1_W'(b1_r[4*k+0]) * pbw_pkg::P1_W'(pix1_r[0]);
      p2_nxt[12*k+1]  = pbw_pkg::P1_W'(b1_r[4*k+2]) * pbw_pkg::P1_W'(pix1_r[1]);
      p2_nxt[12*k+2]  = pbw_pkg::P1_W'(b1_r[4*k+3]) * pbw_pkg::P1_W'(pix1_r[2]);
      p2_nxt[12*k+3]  = pbw_pkg::P1_W'(b1_r[4*k+1]) * pbw_pkg::P1_W'(pix1_r[0]);
      p2_nxt[12*k+4]  = pbw_pkg::P1_W'(b1_r[4*k+3]) * pbw_pkg::P1_W'(pix1_r[1]);
      p2_nxt[12*k+5]  = pbw_pkg::P1_W'(b1_r[4*k+2]) * pbw_pkg::P1_W'(pix1_r[2]);
      // right column of the row: re then im
      p2_nxt[12*k+6]  = pbw_pkg::P1_W'(b1_r[4*k+0]) * pbw_pkg::P1_W'(pix1_r[1]);
      p2_nxt[12*k+7]  = pbw_pkg::P1_W'(b1_r[4*k+1]) * pbw_pkg::P1_W'(pix1_r[2]);
      p2_nxt[12*k+8]  = pbw_pkg::P1_W'(b1_r[4*k+2]) * pbw_pkg::P1_W'(pix1_r[3]);
      p2_nxt[12*k+9]  = pbw_pkg::P1_W'(b1_r[4*k+0]) * pbw_pkg::P1_W'(pix1_r[2]);
      p2_nxt[12*k+10] = pbw_pkg::P1_W'(b1_r[4*k+1]) * pbw_pkg::P1_W'(pix1_r[1]);
      p2_nxt[12*k+11] = pbw_pkg::P1_W'(b1_r[4*k+3]) * pbw_pkg::P1_W'(pix1_r[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 24; i++) begin
        p2_r[i] <= p2_nxt[i];
      end
      for (int i = 0; i < pbw_pkg::NUM_BEAM; i++) begin
        b2_r[i] <= b1_r[i];
      end
    end
  end

  // stage 3: T = B * I
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      t3_nxt[4*k+0] = pbw_pkg::T_W'(p2_r[12*k+0]) + pbw_pkg::T_W'(p2_r[12*k+1])
                    + pbw_pkg::T_W'(p2_r[12*k+2]);
      t3_nxt[4*k+1] = pbw_pkg::T_W'(p2_r[12*k+3]) + pbw_pkg::T_W'(p2_r[12*k+4])
                    - pbw_pkg::T_W'(p2_r[12*k+5]);
      t3_nxt[4*k+2] = pbw_pkg::T_W'(p2_r[12*k+6]) - pbw_pkg::T_W'(p2_r[12*k+7])
                    + pbw_pkg::T_W'(p2_r[12*k+8]);
      t3_nxt[4*k+3] = pbw_pkg::T_W'(p2_r[12*k+9]) + pbw_pkg::T_W'(p2_r[12*k+10])
                    + pbw_pkg::T_W'(p2_r[12*k+11]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 8; i++) begin
        t3_r[i] <= t3_nxt[i];
      end
      for (int i = 0; i < pbw_pkg::NUM_BEAM; i++) begin
        b3_r[i] <= b2_r[i];
      end
    end
  end

  // stage 4: products of T * B^H
  always_comb begin
    // r00 re
    p4_nxt[0]  = pbw_pkg::P2_W'(t3_r[0]) * pbw_pkg::P2_W'(b3_r[0]);
    p4_nxt[1]  = pbw_pkg::P2_W'(t3_r[1]) * pbw_pkg::P2_W'(b3_r[1]);
    p4_nxt[2]  = pbw_pkg::P2_W'(t3_r[2]) * pbw_pkg::P2_W'(b3_r[2]);
    p4_nxt[3]  = pbw_pkg::P2_W'(t3_r[3]) * pbw_pkg::P2_W'(b3_r[3]);
    // r01 re
    p4_nxt[4]  = pbw_pkg::P2_W'(t3_r[0]) * pbw_pkg::P2_W'(b3_r[4]);
    p4_nxt[5]  = pbw_pkg::P2_W'(t3_r[1]) * pbw_pkg::P2_W'(b3_r[5]);
    p4_nxt[6]  = pbw_pkg::P2_W'(t3_r[2]) * pbw_pkg::P2_W'(b3_r[6]);
    p4_nxt[7]  = pbw_pkg::P2_W'(t3_r[3]) * pbw_pkg::P2_W'(b3_r[7]);
    // r01 im
    p4_nxt[8]  = pbw_pkg::P2_W'(t3_r[1]) * pbw_pkg::P2_W'(b3_r[4]);
    p4_nxt[9]  = pbw_pkg::P2_W'(t3_r[0]) * pbw_pkg::P2_W'(b3_r[5]);
    p4_nxt[10] = pbw_pkg::P2_W'(t3_r[3]) * pbw_pkg::P2_W'(b3_r[6]);
    p4_nxt[11] = pbw_pkg::P2_W'(t3_r[2]) * pbw_pkg::P2_W'(b3_r[7]);
    // r11 re
    p4_nxt[12] = pbw_pkg::P2_W'(t3_r[4]) * pbw_pkg::P2_W'(b3_r[4]);
    p4_nxt[13] = pbw_pkg::P2_W'(t3_r[5]) * pbw_pkg::P2_W'(b3_r[5]);
    p4_nxt[14] = pbw_pkg::P2_W'(t3_r[6]) * pbw_pkg::P2_W'(b3_r[6]);
    p4_nxt[15] = pbw_pkg::P2_W'(t3_r[7]) * pbw_pkg::P2_W'(b3_r[7]);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 16; i++) begin
        p4_r[i] <= p4_nxt[i];
      end
    end
  end

  // stage 5: R terms
  always_comb begin
    r5_nxt[0] = pbw_pkg::R_W'(p4_r[0]) + pbw_pkg::R_W'(p4_r[1])
              + pbw_pkg::R_W'(p4_r[2]) + pbw_pkg::R_W'(p4_r[3]);
    r5_nxt[1] = pbw_pkg::R_W'(p4_r[4]) + pbw_pkg::R_W'(p4_r[5])
              + pbw_pkg::R_W'(p4_r[6]) + pbw_pkg::R_W'(p4_r[7]);
    r5_nxt[2] = pbw_pkg::R_W'(p4_r[8]) - pbw_pkg::R_W'(p4_r[9])
              + pbw_pkg::R_W'(p4_r[10]) - pbw_pkg::R_W'(p4_r[11]);
    r5_nxt[3] = pbw_pkg::R_W'(p4_r[12]) + pbw_pkg::R_W'(p4_r[13])
              + pbw_pkg::R_W'(p4_r[14]) + pbw_pkg::R_W'(p4_r[15]);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < pbw_pkg::NUM_OUT; i++) begin
        r5_r[i] <= r5_nxt[i];
      end
    end
  end

  // stages 6 to 8: weighting slices
  assign adv.en_mag = rdy[6];
  assign adv.en_mul = rdy[7];
  assign adv.en_out = rdy[8];

  for (genvar g = 0; g < pbw_pkg::NUM_OUT; g++) begin : g_weigh
    pbw_weigh u_weigh (
      .clk    (clk),
      .adv    (adv),
      .value  (r5_r[g]),
      .weight (weight_r[g]),
      .result (res[g])
    );
  end

  assign out_chan.out_xx      = res[0];
  assign out_chan.out_xy_real = res[1];
  assign out_chan.out_xy_imag = res[2];
  assign out_chan.out_yy      = res[3];

endmodule
`default_nettype wire
